### rtl/quadratic_real_root_solver_macros.svh
// assertion macros for the quadratic real root solver
`ifndef QUADRATIC_REAL_ROOT_SOLVER_MACROS_SVH
`define QUADRATIC_REAL_ROOT_SOLVER_MACROS_SVH

// same-cycle implication
`define QRRS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qrrs assertion failed");

// next-cycle implication
`define QRRS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qrrs assertion failed");

`endif

### rtl/qrrs_pkg.sv
// package for the quadratic real root solver: widths, stage map, types, clamp
package qrrs_pkg;

    localparam int COEF_W     = 16;
    localparam int OUT_W      = 32;
    localparam int OUT_FRAC   = 16;
    localparam int DISC_W     = 2 * COEF_W + 3;
    localparam int SQRT_STEPS = COEF_W + 1;
    localparam int RAD_W      = 2 * SQRT_STEPS;
    localparam int SREM_W     = SQRT_STEPS + 1;
    localparam int NUM_W      = SQRT_STEPS + 1;
    localparam int DEN_W      = COEF_W + 1;
    localparam int DREM_W     = DEN_W;
    localparam int DIV_STEPS  = OUT_W;

    localparam int S_PROD  = 0;
    localparam int S_DISC  = 1;
    localparam int S_SQRT  = 2;
    localparam int S_PREP  = S_SQRT + SQRT_STEPS;
    localparam int S_DIV   = S_PREP + 1;
    localparam int S_OUT   = S_DIV + DIV_STEPS;
    localparam int NST     = S_OUT + 1;

    typedef enum logic [1:0] {
        ST_NONE   = 2'd0,
        ST_ONE    = 2'd1,
        ST_TWO    = 2'd2,
        ST_ZERO_A = 2'd3
    } status_t;

    typedef struct packed {
        logic [SREM_W-1:0]     rem;
        logic [SQRT_STEPS-1:0] root;
        logic [RAD_W-1:0]      rad;
    } sqrt_t;

    typedef struct packed {
        logic [DREM_W-1:0]    rem;
        logic [DIV_STEPS-1:0] num;
        logic [DIV_STEPS-1:0] quo;
        logic [DEN_W-1:0]     den;
    } div_t;

    typedef struct packed {
        status_t                  status;
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic                     neg_p;
        logic                     neg_m;
    } meta_t;

    // {sat, signed result} from an unsigned quotient and a sign
    function automatic logic [OUT_W:0] clamp_root(input logic [OUT_W-1:0] q, input logic neg);
        logic [OUT_W-1:0] lim;
        logic [OUT_W-1:0] mag;
        logic             sat;
        lim = neg ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        sat = (q > lim);
        mag = sat ? lim : q;
        return {sat, (neg ? (~mag + {{(OUT_W-1){1'b0}}, 1'b1}) : mag)};
    endfunction

endpackage

### rtl/qrrs_coef_if.sv
// coefficient channel interface
interface qrrs_coef_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [qrrs_pkg::COEF_W-1:0]    coef_quad;
    logic signed [qrrs_pkg::COEF_W-1:0]    coef_lin;
    logic signed [qrrs_pkg::COEF_W-1:0]    coef_const;

    modport source (output valid, coef_quad, coef_lin, coef_const, input ready);
    modport sink (input valid, coef_quad, coef_lin, coef_const, output ready);
endinterface

### rtl/qrrs_root_if.sv
// root result channel interface
interface qrrs_root_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          root_status;
    logic signed [qrrs_pkg::OUT_W-1:0]   root_plus;
    logic signed [qrrs_pkg::OUT_W-1:0]   root_minus;
    logic                                saturated;

    modport source (output valid, root_status, root_plus, root_minus, saturated, input ready);
    modport sink (input valid, root_status, root_plus, root_minus, saturated, output ready);
endinterface

### rtl/qrrs_sqrt_cell.sv
// one restoring square root cell: two radicand bits in, one root bit out
module qrrs_sqrt_cell (
    input  logic              clk,
    input  logic              en,
    input  qrrs_pkg::sqrt_t   din,
    output qrrs_pkg::sqrt_t   dout
);

    logic [qrrs_pkg::SREM_W+1:0] r2;
    logic [qrrs_pkg::SREM_W+1:0] trial;
    logic [qrrs_pkg::SREM_W+1:0] diff;
    logic                        fits;
    qrrs_pkg::sqrt_t             dout_next;
    qrrs_pkg::sqrt_t             dout_reg;

    always_comb
    begin
        r2    = {din.rem, din.rad[qrrs_pkg::RAD_W-1 -: 2]};
        trial = {1'b0, din.root, 2'b01};
        diff  = r2 - trial;
        fits  = (r2 >= trial);
        dout_next.rem  = fits ? diff[qrrs_pkg::SREM_W-1:0] : r2[qrrs_pkg::SREM_W-1:0];
        dout_next.root = {din.root[qrrs_pkg::SQRT_STEPS-2:0], fits};
        dout_next.rad  = {din.rad[qrrs_pkg::RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

### rtl/qrrs_div_cell.sv
// one restoring divider cell: one quotient bit per cell
module qrrs_div_cell (
    input  logic             clk,
    input  logic             en,
    input  qrrs_pkg::div_t   din,
    output qrrs_pkg::div_t   dout
);

    logic [qrrs_pkg::DREM_W:0] r2;
    logic [qrrs_pkg::DREM_W:0] dsr;
    logic [qrrs_pkg::DREM_W:0] diff;
    logic                      fits;
    qrrs_pkg::div_t            dout_next;
    qrrs_pkg::div_t            dout_reg;

    always_comb
    begin
        r2   = {din.rem, din.num[qrrs_pkg::DIV_STEPS-1]};
        dsr  = {1'b0, din.den};
        diff = r2 - dsr;
        fits = (r2 >= dsr);
        dout_next.rem = fits ? diff[qrrs_pkg::DREM_W-1:0] : r2[qrrs_pkg::DREM_W-1:0];
        dout_next.num = {din.num[qrrs_pkg::DIV_STEPS-2:0], 1'b0};
        dout_next.quo = {din.quo[qrrs_pkg::DIV_STEPS-2:0], fits};
        dout_next.den = din.den;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

### rtl/quadratic_real_root_solver.sv
// throughput: one coefficient set per cycle while the output is not stalled, every stage is a pipeline register
// depth set by the 17-cell square root chain and the two 32-cell divider chains
// stalled stages hold, empty stages fill, so bubbles close up under back-pressure
// reset clears the stage valid bits only, payload registers are not reset
`include "quadratic_real_root_solver_macros.svh"

module quadratic_real_root_solver (
    input  logic        clk,
    input  logic        rst_n,
    qrrs_coef_if.sink   coef,
    qrrs_root_if.source root
);

    logic [qrrs_pkg::NST-1:0]              valid_reg;
    logic [qrrs_pkg::NST-1:0]              en;

    qrrs_pkg::meta_t                       meta_reg  [qrrs_pkg::S_OUT];
    qrrs_pkg::meta_t                       meta_next [qrrs_pkg::S_OUT];

    logic signed [2*qrrs_pkg::COEF_W-1:0]  bb_reg;
    logic signed [2*qrrs_pkg::COEF_W-1:0]  ac_reg;
    logic signed [qrrs_pkg::DISC_W-1:0]    disc;
    qrrs_pkg::status_t                     disc_status;
    qrrs_pkg::sqrt_t                       sq_in_next;

    qrrs_pkg::sqrt_t                       sq [qrrs_pkg::SQRT_STEPS+1];
    qrrs_pkg::div_t                        dp [qrrs_pkg::DIV_STEPS+1];
    qrrs_pkg::div_t                        dm [qrrs_pkg::DIV_STEPS+1];

    logic signed [qrrs_pkg::NUM_W-1:0]     num_p;
    logic signed [qrrs_pkg::NUM_W-1:0]     num_m;
    logic signed [qrrs_pkg::NUM_W-1:0]     neg_b;
    logic signed [qrrs_pkg::DEN_W-1:0]     den;
    logic [qrrs_pkg::NUM_W-2:0]            mag_p;
    logic [qrrs_pkg::NUM_W-2:0]            mag_m;
    logic [qrrs_pkg::DEN_W-1:0]            mag_den;
    qrrs_pkg::div_t                        dp_in_next;
    qrrs_pkg::div_t                        dm_in_next;

    logic [qrrs_pkg::OUT_W:0]              clamp_p;
    logic [qrrs_pkg::OUT_W:0]              clamp_m;
    qrrs_pkg::status_t                     status_next;
    qrrs_pkg::status_t                     status_reg;
    logic [qrrs_pkg::OUT_W-1:0]            plus_next;
    logic [qrrs_pkg::OUT_W-1:0]            plus_reg;
    logic [qrrs_pkg::OUT_W-1:0]            minus_next;
    logic [qrrs_pkg::OUT_W-1:0]            minus_reg;
    logic                                  sat_next;
    logic                                  sat_reg;

    // elastic advance: a stage loads when it is empty or its successor loads
    always_comb
    begin
        en[qrrs_pkg::NST-1] = !valid_reg[qrrs_pkg::NST-1] || root.ready;
        for (int i = qrrs_pkg::NST - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    assign coef.ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= coef.valid;
            end
            for (int i = 1; i < qrrs_pkg::NST; i++)
            begin
                if (en[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // discriminant and classification
    always_comb
    begin
        disc = $signed({{3{bb_reg[2*qrrs_pkg::COEF_W-1]}}, bb_reg})
             - $signed({ac_reg[2*qrrs_pkg::COEF_W-1], ac_reg, 2'b00});
        if (meta_reg[qrrs_pkg::S_PROD].a == '0)
        begin
            disc_status = qrrs_pkg::ST_ZERO_A;
        end
        else if (disc[qrrs_pkg::DISC_W-1])
        begin
            disc_status = qrrs_pkg::ST_NONE;
        end
        else if (disc == '0)
        begin
            disc_status = qrrs_pkg::ST_ONE;
        end
        else
        begin
            disc_status = qrrs_pkg::ST_TWO;
        end
        sq_in_next.rem  = '0;
        sq_in_next.root = '0;
        sq_in_next.rad  = {1'b0, disc[qrrs_pkg::RAD_W-2:0]};
    end

    // numerators and divisor from the square root
    always_comb
    begin
        neg_b   = -$signed({{2{meta_reg[qrrs_pkg::S_PREP-1].b[qrrs_pkg::COEF_W-1]}},
                             meta_reg[qrrs_pkg::S_PREP-1].b});
        num_p   = neg_b + $signed({1'b0, sq[qrrs_pkg::SQRT_STEPS].root});
        num_m   = neg_b - $signed({1'b0, sq[qrrs_pkg::SQRT_STEPS].root});
        den     = {meta_reg[qrrs_pkg::S_PREP-1].a, 1'b0};
        mag_p   = num_p[qrrs_pkg::NUM_W-1] ? (~num_p[qrrs_pkg::NUM_W-2:0]
                  + {{(qrrs_pkg::NUM_W-2){1'b0}}, 1'b1}) : num_p[qrrs_pkg::NUM_W-2:0];
        mag_m   = num_m[qrrs_pkg::NUM_W-1] ? (~num_m[qrrs_pkg::NUM_W-2:0]
                  + {{(qrrs_pkg::NUM_W-2){1'b0}}, 1'b1}) : num_m[qrrs_pkg::NUM_W-2:0];
        mag_den = den[qrrs_pkg::DEN_W-1] ? (~den + {{(qrrs_pkg::DEN_W-1){1'b0}}, 1'b1}) : den;

        dp_in_next.rem = {{(qrrs_pkg::DREM_W-1){1'b0}}, mag_p[qrrs_pkg::NUM_W-2]};
        dp_in_next.num = {mag_p[qrrs_pkg::NUM_W-3:0], {qrrs_pkg::OUT_FRAC{1'b0}}};
        dp_in_next.quo = '0;
        dp_in_next.den = mag_den;
        dm_in_next.rem = {{(qrrs_pkg::DREM_W-1){1'b0}}, mag_m[qrrs_pkg::NUM_W-2]};
        dm_in_next.num = {mag_m[qrrs_pkg::NUM_W-3:0], {qrrs_pkg::OUT_FRAC{1'b0}}};
        dm_in_next.quo = '0;
        dm_in_next.den = mag_den;
    end

    // side information travelling with each transaction
    always_comb
    begin
        meta_next[0].status = qrrs_pkg::ST_NONE;
        meta_next[0].a      = coef.coef_quad;
        meta_next[0].b      = coef.coef_lin;
        meta_next[0].neg_p  = 1'b0;
        meta_next[0].neg_m  = 1'b0;
        for (int i = 1; i < qrrs_pkg::S_OUT; i++)
        begin
            meta_next[i] = meta_reg[i-1];
        end
        meta_next[qrrs_pkg::S_DISC].status = disc_status;
        meta_next[qrrs_pkg::S_PREP].neg_p  =
            (num_p[qrrs_pkg::NUM_W-1] != den[qrrs_pkg::DEN_W-1]) && (num_p != '0);
        meta_next[qrrs_pkg::S_PREP].neg_m  =
            (num_m[qrrs_pkg::NUM_W-1] != den[qrrs_pkg::DEN_W-1]) && (num_m != '0);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < qrrs_pkg::S_OUT; i++)
        begin
            if (en[i])
            begin
                meta_reg[i] <= meta_next[i];
            end
        end
        if (en[qrrs_pkg::S_PROD])
        begin
            bb_reg <= coef.coef_lin * coef.coef_lin;
            ac_reg <= coef.coef_quad * coef.coef_const;
        end
        if (en[qrrs_pkg::S_DISC])
        begin
            sq[0] <= sq_in_next;
        end
        if (en[qrrs_pkg::S_PREP])
        begin
            dp[0] <= dp_in_next;
            dm[0] <= dm_in_next;
        end
        if (en[qrrs_pkg::S_OUT])
        begin
            status_reg <= status_next;
            plus_reg   <= plus_next;
            minus_reg  <= minus_next;
            sat_reg    <= sat_next;
        end
    end

    for (genvar k = 0; k < qrrs_pkg::SQRT_STEPS; k++)
    begin : g_sqrt
        qrrs_sqrt_cell u_cell (
            .clk  (clk),
            .en   (en[qrrs_pkg::S_SQRT + k]),
            .din  (sq[k]),
            .dout (sq[k+1])
        );
    end

    for (genvar k = 0; k < qrrs_pkg::DIV_STEPS; k++)
    begin : g_div
        qrrs_div_cell u_plus (
            .clk  (clk),
            .en   (en[qrrs_pkg::S_DIV + k]),
            .din  (dp[k]),
            .dout (dp[k+1])
        );
        qrrs_div_cell u_minus (
            .clk  (clk),
            .en   (en[qrrs_pkg::S_DIV + k]),
            .din  (dm[k]),
            .dout (dm[k+1])
        );
    end

    // sign, saturation and masking by status
    always_comb
    begin
        clamp_p     = qrrs_pkg::clamp_root(dp[qrrs_pkg::DIV_STEPS].quo,
                                           meta_reg[qrrs_pkg::S_OUT-1].neg_p);
        clamp_m     = qrrs_pkg::clamp_root(dm[qrrs_pkg::DIV_STEPS].quo,
                                           meta_reg[qrrs_pkg::S_OUT-1].neg_m);
        status_next = meta_reg[qrrs_pkg::S_OUT-1].status;
        case (status_next)
            qrrs_pkg::ST_ONE:
            begin
                plus_next  = clamp_p[qrrs_pkg::OUT_W-1:0];
                minus_next = '0;
                sat_next   = clamp_p[qrrs_pkg::OUT_W];
            end
            qrrs_pkg::ST_TWO:
            begin
                plus_next  = clamp_p[qrrs_pkg::OUT_W-1:0];
                minus_next = clamp_m[qrrs_pkg::OUT_W-1:0];
                sat_next   = clamp_p[qrrs_pkg::OUT_W] | clamp_m[qrrs_pkg::OUT_W];
            end
            default:
            begin
                plus_next  = '0;
                minus_next = '0;
                sat_next   = 1'b0;
            end
        endcase
    end

    assign root.valid       = valid_reg[qrrs_pkg::S_OUT];
    assign root.root_status = status_reg;
    assign root.root_plus   = plus_reg;
    assign root.root_minus  = minus_reg;
    assign root.saturated   = sat_reg;

    `QRRS_ASSERT_NOW(a_ready_when_out_empty, !valid_reg[qrrs_pkg::S_OUT], coef.ready)
    `QRRS_ASSERT_NOW(a_no_root_zero, root.valid && (status_reg == qrrs_pkg::ST_NONE || status_reg == qrrs_pkg::ST_ZERO_A), plus_reg == '0 && minus_reg == '0 && !sat_reg)
    `QRRS_ASSERT_NOW(a_single_minus_zero, root.valid && status_reg == qrrs_pkg::ST_ONE, minus_reg == '0)
    `QRRS_ASSERT_NEXT(a_stall_holds_out, root.valid && !root.ready, valid_reg[qrrs_pkg::S_OUT] && $stable(plus_reg) && $stable(minus_reg))

endmodule

### dv/testbench.sv
// testbench for the quadratic real root solver: predicted roots checked per transaction
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        qrrs_pkg::status_t status;
        logic [31:0]       rplus;
        logic [31:0]       rminus;
        logic              sat;
    } roots_t;

    logic clk;
    logic rst_n;
    int   cycles;
    int   errors;
    int   mismatches;
    int   sent;
    int   received;
    int   src_idle_pct;
    int   snk_idle_pct;
    bit   hold_off;
    roots_t pending_roots[$];

    qrrs_coef_if coef_ch();
    qrrs_root_if root_ch();

    quadratic_real_root_solver u_top (
        .clk  (clk),
        .rst_n(rst_n),
        .coef (coef_ch.sink),
        .root (root_ch.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("testbench: errors");
            $finish;
        end
    end

    // quotient in Q16.16, truncated toward zero, clamped
    function automatic logic [31:0] root_value(input longint num, input longint den,
                                               inout logic sat);
        longint unsigned q;
        longint unsigned nm;
        longint unsigned dm;
        bit neg;
        nm = (num < 0) ? -num : num;
        dm = (den < 0) ? -den : den;
        q = (nm << 16) / dm;
        neg = (num < 0) != (den < 0);
        if (neg)
        begin
            if (q > 64'h8000_0000)
            begin
                sat = 1'b1;
                q = 64'h8000_0000;
            end
            return 32'(-q);
        end
        if (q > 64'h7FFF_FFFF)
        begin
            sat = 1'b1;
            q = 64'h7FFF_FFFF;
        end
        return q[31:0];
    endfunction

    // discriminant stays below 2^34, so the root stays below 2^20
    function automatic longint floor_sqrt(input longint d);
        longint lo;
        longint hi;
        longint mid;
        lo = 0;
        hi = longint'(1) << 20;
        while (hi - lo > 1)
        begin
            mid = lo + ((hi - lo) >> 1);
            if (mid * mid <= d)
                lo = mid;
            else
                hi = mid;
        end
        return lo;
    endfunction

    function automatic roots_t solve_roots(input logic signed [15:0] qa,
                                           input logic signed [15:0] qb,
                                           input logic signed [15:0] qc);
        roots_t r;
        longint a;
        longint b;
        longint c;
        longint disc;
        longint s;
        a = qa;
        b = qb;
        c = qc;
        r.status = qrrs_pkg::ST_NONE;
        r.rplus = '0;
        r.rminus = '0;
        r.sat = 1'b0;
        if (a == 0)
        begin
            r.status = qrrs_pkg::ST_ZERO_A;
            return r;
        end
        disc = b * b - 4 * a * c;
        if (disc < 0)
            r.status = qrrs_pkg::ST_NONE;
        else if (disc == 0)
        begin
            r.status = qrrs_pkg::ST_ONE;
            r.rplus = root_value(-b, 2 * a, r.sat);
        end
        else
        begin
            s = floor_sqrt(disc);
            r.status = qrrs_pkg::ST_TWO;
            r.rplus = root_value(-b + s, 2 * a, r.sat);
            r.rminus = root_value(-b - s, 2 * a, r.sat);
        end
        return r;
    endfunction

    task automatic send_coefs(input logic [15:0] a, input logic [15:0] b,
                              input logic [15:0] c);
        while ($urandom_range(99) < src_idle_pct)
        begin
            coef_ch.valid <= 1'b0;
            @(negedge clk);
        end
        coef_ch.valid <= 1'b1;
        coef_ch.coef_quad <= a;
        coef_ch.coef_lin <= b;
        coef_ch.coef_const <= c;
        do
            @(posedge clk);
        while (!coef_ch.ready);
        pending_roots.push_back(solve_roots(a, b, c));
        sent++;
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (hold_off)
            root_ch.ready <= 1'b0;
        else
            root_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge clk)
    begin
        roots_t e;
        if (rst_n && root_ch.valid && root_ch.ready)
        begin
            received++;
            if (pending_roots.size() == 0)
            begin
                errors++;
                $display("unexpected root transaction");
            end
            else
            begin
                e = pending_roots.pop_front();
                if (root_ch.root_status !== e.status || root_ch.root_plus !== e.rplus
                    || root_ch.root_minus !== e.rminus || root_ch.saturated !== e.sat)
                begin
                    errors++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d %h %h %b got %0d %h %h %b",
                                 e.status, e.rplus, e.rminus, e.sat,
                                 root_ch.root_status, root_ch.root_plus,
                                 root_ch.root_minus, root_ch.saturated);
                end
            end
        end
    end

    function automatic logic [15:0] pick_coef();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'(int'($urandom_range(0, 64)) - 32);
            3: return 16'(int'($urandom_range(0, 1024)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        logic [15:0] ext[6];
        ext = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF, 16'h0100};
        send_coefs(16'h0000, 16'h0100, 16'h0100);
        send_coefs(16'h0100, 16'h0000, 16'h0100);
        send_coefs(16'h0100, 16'h0200, 16'h0100);
        send_coefs(16'h0100, 16'h0000, 16'hFF00);
        send_coefs(16'h0001, 16'h0000, 16'h0000);
        send_coefs(16'h0001, 16'h7FFF, 16'h0000);
        send_coefs(16'h0001, 16'h8000, 16'h0000);
        send_coefs(16'h0004, 16'h0001, 16'h0000);
        send_coefs(16'h0004, 16'h0000, 16'hFFFF);
        for (int i = 0; i < 6; i++)
            send_coefs(ext[i], ext[(i + 1) % 6], ext[(i + 3) % 6]);
        send_coefs(16'h8000, 16'h8000, 16'h8000);
        send_coefs(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_coefs(16'h8000, 16'h7FFF, 16'h7FFF);
    endtask

    task automatic test_random(input int count);
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
        for (int i = 0; i < count; i++)
        begin
            a = pick_coef();
            b = pick_coef();
            c = pick_coef();
            if ($urandom_range(7) == 0)
                c = 16'((longint'($signed(b)) * $signed(b)) / (4 * (a == 0 ? 1 : $signed(a))));
            send_coefs(a, b, c);
        end
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(negedge clk);
                hold_off = 1'b0;
            end
            test_random(150);
        join
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        coef_ch.valid <= 1'b0;
        while (pending_roots.size() != 0 && guard < 20000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (80) @(negedge clk);
    endtask

    initial
    begin
        cycles = 0;
        errors = 0;
        mismatches = 0;
        sent = 0;
        received = 0;
        hold_off = 1'b0;
        src_idle_pct = 33;
        snk_idle_pct = 48;
        rst_n = 1'b0;
        coef_ch.valid = 1'b0;
        coef_ch.coef_quad = '0;
        coef_ch.coef_lin = '0;
        coef_ch.coef_const = '0;
        root_ch.ready = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random(500);
        src_idle_pct = 48;
        snk_idle_pct = 33;
        test_random(500);
        test_backpressure();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random(480);
        drain();
        if (pending_roots.size() != 0)
            errors++;
        $display("sent %0d coefficient sets, checked %0d root transactions, %0d mismatches",
                 sent, received, mismatches);
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule

### files.f
+incdir+rtl
rtl/qrrs_pkg.sv
rtl/qrrs_coef_if.sv
rtl/qrrs_root_if.sv
rtl/qrrs_sqrt_cell.sv
rtl/qrrs_div_cell.sv
rtl/quadratic_real_root_solver.sv
dv/testbench.sv
